// File: rtl/light_to_brightness_deadband_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the light-to-brightness block
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef LIGHT_TO_BRIGHTNESS_DEADBAND_ASSERT_SVH
`define LIGHT_TO_BRIGHTNESS_DEADBAND_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define LTBD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define LTBD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/ltbd_pkg.sv
// ----------------------------------------------------------------------------
// ltbd_pkg
// Widths, codes, breakpoint curve and shared types of the
// light-to-brightness block.
// ----------------------------------------------------------------------------
package ltbd_pkg;

	// Field widths.
	localparam int LEVEL_W    = 16;
	localparam int STATUS_W   = 2;
	localparam int BRIGHT_W   = 14;
	localparam int DEADBAND_W = 16;
	localparam int CONFIRM_W  = 4;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int DATA_IN_W  = 16;
	localparam int DATA_OUT_W = 32;

	// Curve storage widths and derived divider widths.
	localparam int X_W   = 12;
	localparam int Y_W   = 14;
	localparam int NUM_W = Y_W + X_W;
	localparam int DEN_W = X_W;

	// Breakpoint curve.
	localparam int TABLE_LEN       = 8;
	localparam int BREAKPOINTS_DEF = 8;
	localparam logic [X_W-1:0] CURVE_X [TABLE_LEN] = '{
		12'd0, 12'd80, 12'd100, 12'd200, 12'd300, 12'd500, 12'd1400, 12'd3355
	};
	localparam logic [Y_W-1:0] CURVE_Y [TABLE_LEN] = '{
		14'd500, 14'd3000, 14'd4500, 14'd5000, 14'd6000, 14'd7000, 14'd8500, 14'd10000
	};

	// Reset values of the programmable and tracked state.
	localparam logic [LEVEL_W-1:0]    REF_RESET      = 16'hFFFF;
	localparam logic [DEADBAND_W-1:0] DEADBAND_RESET = 16'd50;
	localparam logic [CONFIRM_W-1:0]  CONFIRM_RESET  = 4'd3;

	// Read status codes.
	localparam logic [STATUS_W-1:0] ST_GOOD  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_PARSE = 2'd1;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_CONFIRM  = 1'b1;

	// Segment selected for one level.
	typedef struct packed {
		logic [Y_W-1:0] y0;
		logic [Y_W-1:0] dy;
		logic [X_W-1:0] dx;
		logic [X_W-1:0] off;
	} seg_t;

	// Divider request and response.
	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic [NUM_W-1:0] quot;
	} div_rsp_t;

endpackage

// File: rtl/ltbd_div.sv
// ----------------------------------------------------------------------------
// ltbd_div
// Restoring divider, one quotient bit per cycle, unsigned.
// ----------------------------------------------------------------------------
module ltbd_div
	import ltbd_pkg::*;
#(
	parameter int N_W = NUM_W,
	parameter int D_W = DEN_W
) (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(N_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [D_W-1:0]   rem_q;
	logic [D_W-1:0]   den_q;
	logic [N_W-1:0]   quot_q;
	logic [D_W:0]     trial;
	logic [D_W:0]     diff;
	logic             qbit;

	// Shift in the next numerator bit and try the subtraction.
	always_comb begin
		trial = {rem_q, quot_q[N_W-1]};
		diff  = trial - {1'b0, den_q};
		qbit  = (trial >= {1'b0, den_q});
	end

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.start) begin
			cnt_q <= CNT_W'(N_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// Partial remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= '0;
			den_q  <= req.den;
			quot_q <= req.num;
		end else if (cnt_q != '0) begin
			rem_q  <= qbit ? diff[D_W-1:0] : trial[D_W-1:0];
			quot_q <= {quot_q[N_W-2:0], qbit};
		end
	end

	assign rsp.busy = (cnt_q != '0);
	assign rsp.quot = quot_q;

endmodule

// File: rtl/ltbd_seg.sv
// ----------------------------------------------------------------------------
// ltbd_seg
// Finds the curve segment for a level and returns its base point,
// rise, run and the offset of the level into it.
// ----------------------------------------------------------------------------
module ltbd_seg
	import ltbd_pkg::*;
#(
	parameter int BREAKPOINTS = BREAKPOINTS_DEF
) (
	input  logic [LEVEL_W-1:0] x,
	output seg_t               seg
);

	localparam int POINTS = (BREAKPOINTS < TABLE_LEN) ? BREAKPOINTS : TABLE_LEN;
	localparam int X_PAD  = LEVEL_W - X_W;

	// Segments are disjoint, so at most one of them matches. Levels at or
	// below the first point and above the last give a flat result.
	always_comb begin
		logic [LEVEL_W-1:0] diff;
		diff     = '0;
		seg.y0   = CURVE_Y[0];
		seg.dy   = '0;
		seg.dx   = X_W'(1);
		seg.off  = '0;
		if (x > {{X_PAD{1'b0}}, CURVE_X[POINTS-1]}) begin
			seg.y0 = CURVE_Y[POINTS-1];
		end
		for (int i = 1; i < POINTS; i++) begin
			if (x > {{X_PAD{1'b0}}, CURVE_X[i-1]} && x <= {{X_PAD{1'b0}}, CURVE_X[i]}) begin
				diff    = x - {{X_PAD{1'b0}}, CURVE_X[i-1]};
				seg.y0  = CURVE_Y[i-1];
				seg.dy  = CURVE_Y[i] - CURVE_Y[i-1];
				seg.dx  = CURVE_X[i] - CURVE_X[i-1];
				seg.off = diff[X_W-1:0];
			end
		end
	end

endmodule

// File: rtl/light_to_brightness_deadband.sv
// ----------------------------------------------------------------------------
// light_to_brightness_deadband
// Deadband filter on ambient-light samples with a confirm counter, and
// piecewise-linear brightness lookup for each newly accepted level.
//
//   Channel  Dir  Handshake           Payload
//   s_       in   s_tvalid/s_tready   tdata: sample; tuser: read_status
//   m_       out  m_tvalid/m_tready   tdata: brightness, level
//   cfg_     in   cfg_we              cfg_index, cfg_data
//
// A sample that does not move the level leaves the input ready.
// A sample that moves the level runs segment lookup, one multiply and a
// 26-step serial divide in states S_SEG, S_MUL, S_DIV and S_OUT; the
// input is not ready meanwhile. S_OUT waits until the output register
// is free; once the result is loaded there, the input is ready again
// and the next sample can be taken while it waits for m_tready. Reset
// clears control, tracking and output valid state, not the datapath.
// ----------------------------------------------------------------------------
module light_to_brightness_deadband
	import ltbd_pkg::*;
#(
	parameter int BREAKPOINTS = BREAKPOINTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [DATA_IN_W-1:0]  s_tdata,   // [15:0] sample
	input  logic [STATUS_W-1:0]   s_tuser,   // [1:0] read_status
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [DATA_OUT_W-1:0] m_tdata,   // [13:0] brightness, [29:14] level
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SEG  = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	localparam int OUT_PAD = DATA_OUT_W - LEVEL_W - BRIGHT_W;

	logic [2:0]            state_q;
	logic [DEADBAND_W-1:0] deadband_q;
	logic [CONFIRM_W-1:0]  confirm_q;
	logic [LEVEL_W-1:0]    ref_q;
	logic [CONFIRM_W-1:0]  cnt_q;
	logic [LEVEL_W-1:0]    last_q;
	logic [LEVEL_W-1:0]    x_q;
	seg_t                  seg_q;
	seg_t                  seg_c;
	logic                  m_valid_q;
	logic [BRIGHT_W-1:0]   bright_q;
	logic [LEVEL_W-1:0]    level_q;

	logic                  in_acc;
	logic [LEVEL_W-1:0]    new_last;
	logic [LEVEL_W:0]      upper;
	logic [LEVEL_W:0]      low_sum;
	logic                  outside;
	logic                  take;
	logic                  out_free;
	logic [BRIGHT_W-1:0]   bright_c;
	div_req_t              div_req;
	div_rsp_t              div_rsp;

	assign s_tready = (state_q == S_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;

	// Pick the sample that counts, then test it against the band.
	always_comb begin
		case (s_tuser)
			ST_GOOD:  new_last = s_tdata[LEVEL_W-1:0];
			ST_PARSE: new_last = '0;
			default:  new_last = last_q;
		endcase
		upper   = {1'b0, ref_q} + {1'b0, deadband_q};
		low_sum = {1'b0, new_last} + {1'b0, deadband_q};
		outside = ({1'b0, new_last} > upper) || (low_sum < {1'b0, ref_q});
		take    = outside && (cnt_q >= confirm_q);
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q <= DEADBAND_RESET;
			confirm_q  <= CONFIRM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEADBAND: deadband_q <= cfg_data[DEADBAND_W-1:0];
				REG_CONFIRM:  confirm_q  <= cfg_data[CONFIRM_W-1:0];
				default:      ;
			endcase
		end
	end

	// Reference level, confirm counter and last sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q  <= REF_RESET;
			cnt_q  <= '0;
			last_q <= '0;
		end else if (in_acc) begin
			last_q <= new_last;
			if (take) begin
				ref_q <= new_last;
				cnt_q <= '0;
			end else if (outside) begin
				cnt_q <= cnt_q + CONFIRM_W'(1);
			end
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_acc && take) state_q <= S_SEG;
				S_SEG:  state_q <= S_MUL;
				S_MUL:  state_q <= S_DIV;
				S_DIV:  if (!div_rsp.busy) state_q <= S_OUT;
				S_OUT:  if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Level and segment registers.
	always_ff @(posedge clk) begin
		if (in_acc && take) begin
			x_q <= new_last;
		end
		if (state_q == S_SEG) begin
			seg_q <= seg_c;
		end
	end

	ltbd_seg #(
		.BREAKPOINTS(BREAKPOINTS)
	) u_seg (
		.x   (x_q),
		.seg (seg_c)
	);

	// The product feeds the divider, which registers it on start.
	always_comb begin
		div_req.start = (state_q == S_MUL);
		div_req.num   = NUM_W'(seg_q.dy) * NUM_W'(seg_q.off);
		div_req.den   = seg_q.dx;
	end

	ltbd_div #(
		.N_W(NUM_W),
		.D_W(DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign bright_c = seg_q.y0 + div_rsp.quot[BRIGHT_W-1:0];

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			bright_q <= bright_c;
			level_q  <= x_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{OUT_PAD{1'b0}}, level_q, bright_q};

endmodule

// File: rtl/ltbd_chk.sv
// ----------------------------------------------------------------------------
// ltbd_chk
// Port checker for the light-to-brightness block, bound to the top level.
// ----------------------------------------------------------------------------
`include "light_to_brightness_deadband_assert.svh"

module ltbd_chk
	import ltbd_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [DATA_OUT_W-1:0] m_tdata
);

	// A stalled result item holds its value.
	`LTBD_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result item changed while stalled")

	// Brightness stays within the curve's range.
	`LTBD_ASSERT_IMP(a_bright_range, clk, arst_n, m_tvalid, (m_tdata[13:0] >= 14'd500) && (m_tdata[13:0] <= 14'd10000), "brightness out of range")

	// A dark level maps to the first breakpoint.
	`LTBD_ASSERT_IMP(a_dark_level, clk, arst_n, m_tvalid && (m_tdata[29:14] == 16'd0), m_tdata[13:0] == 14'd500, "zero level did not give minimum brightness")

	// A new result only appears after the block has been busy computing it.
	`LTBD_ASSERT_IMP(a_busy_before_out, clk, arst_n, $rose(m_tvalid), $past(!s_tready), "result appeared without a busy phase")

endmodule

bind light_to_brightness_deadband ltbd_chk u_chk (.*);

// File: tb/sv/light_to_brightness_deadband_checker.sv
// ----------------------------------------------------------------------------
// light_to_brightness_deadband_checker
// Watches the sample, result and register channels of the deadband block.
// It tracks the reference level, confirm counter and held sample. For every
// accepted sample it predicts whether a new level is taken and at what
// brightness. Each accepted result is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module light_to_brightness_deadband_checker
	import ltbd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [DATA_IN_W-1:0]  s_tdata,   // [15:0] sample
	input  logic [STATUS_W-1:0]   s_tuser,   // [1:0] read_status
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [DATA_OUT_W-1:0] m_tdata,   // [13:0] brightness, [29:14] level
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	output int                    fail_count,
	output int                    pending,
	output int                    level_changes
);

	// One predicted level change.
	typedef struct {
		logic [BRIGHT_W-1:0] brightness;
		logic [LEVEL_W-1:0]  level;
	} level_change_t;

	// Brightness curve: illuminance knees and their brightness.
	localparam int KNEES = 8;
	localparam int KNEE_X [KNEES] = '{0, 80, 100, 200, 300, 500, 1400, 3355};
	localparam int KNEE_Y [KNEES] = '{500, 3000, 4500, 5000, 6000, 7000, 8500, 10000};

	logic [DEADBAND_W-1:0] band_half;
	logic [CONFIRM_W-1:0]  confirm_limit;
	logic [LEVEL_W-1:0]    ref_level;
	logic [LEVEL_W-1:0]    held_sample;
	logic [CONFIRM_W-1:0]  outside_count;
	level_change_t         level_q [$];

	// Brightness for an illuminance level; all terms are positive, so the
	// integer division is already the floor.
	function automatic int brightness_at(input int x);
		int i;
		if (x <= KNEE_X[0])
			return KNEE_Y[0];
		for (i = 1; i < KNEES; i++) begin
			if (x <= KNEE_X[i])
				return KNEE_Y[i-1] + ((KNEE_Y[i] - KNEE_Y[i-1]) * (x - KNEE_X[i-1]))
					/ (KNEE_X[i] - KNEE_X[i-1]);
		end
		return KNEE_Y[KNEES-1];
	endfunction

	// Predict on accepted samples, check accepted results.
	always @(posedge clk or negedge arst_n) begin
		level_change_t got;
		level_change_t want;
		int upper;
		int lower;
		if (!arst_n) begin
			band_half     = 16'd50;
			confirm_limit = 4'd3;
			ref_level     = 16'hFFFF;
			held_sample   = '0;
			outside_count = '0;
			level_q.delete();
			fail_count    = 0;
			pending       = 0;
			level_changes = 0;
		end else begin
			// Results come long after their sample, so check them first.
			if (m_tvalid && m_tready) begin
				got.brightness = m_tdata[BRIGHT_W-1:0];
				got.level      = m_tdata[BRIGHT_W+LEVEL_W-1:BRIGHT_W];
				if (level_q.size() == 0) begin
					$error("unexpected result: brightness %0d, level %0d",
						got.brightness, got.level);
					fail_count++;
				end else begin
					want = level_q.pop_front();
					level_changes++;
					if (got.brightness != want.brightness) begin
						$error("brightness mismatch: expected %0d, actual %0d",
							want.brightness, got.brightness);
						fail_count++;
					end
					if (got.level != want.level) begin
						$error("level mismatch: expected %0d, actual %0d",
							want.level, got.level);
						fail_count++;
					end
					if (m_tdata[DATA_OUT_W-1:BRIGHT_W+LEVEL_W] != '0) begin
						$error("tdata padding mismatch: expected 0, actual %0d",
							m_tdata[DATA_OUT_W-1:BRIGHT_W+LEVEL_W]);
						fail_count++;
					end
				end
			end

			// Register writes; only the low bits of each register count.
			if (cfg_we) begin
				case (cfg_index)
					REG_DEADBAND: band_half     = cfg_data[DEADBAND_W-1:0];
					REG_CONFIRM:  confirm_limit = cfg_data[CONFIRM_W-1:0];
					default: ;
				endcase
			end

			// Deadband and confirm logic for an accepted sample.
			if (s_tvalid && s_tready) begin
				if (s_tuser == ST_GOOD)
					held_sample = s_tdata[LEVEL_W-1:0];
				else if (s_tuser == ST_PARSE)
					held_sample = '0;
				upper = int'(ref_level) + int'(band_half);
				lower = int'(ref_level) - int'(band_half);
				if (int'(held_sample) > upper || int'(held_sample) < lower) begin
					if (outside_count >= confirm_limit) begin
						ref_level       = held_sample;
						outside_count   = '0;
						want.brightness = BRIGHT_W'(brightness_at(int'(held_sample)));
						want.level      = held_sample;
						level_q.push_back(want);
					end else begin
						outside_count = outside_count + 1'b1;
					end
				end
			end
			pending = level_q.size();
		end
	end

endmodule

// File: tb/sv/light_to_brightness_deadband_tb.sv
// ----------------------------------------------------------------------------
// light_to_brightness_deadband_tb
// Drives light samples and register writes into the deadband block and lets
// the checker predict and compare every level change. A directed opening
// covers the status codes, curve ends and confirm count corner cases, then
// random runs of steady levels and noise play under four idle/stall mixes.
// ----------------------------------------------------------------------------
module light_to_brightness_deadband_tb;
	import ltbd_pkg::*;

	// Read status codes that the package leaves unnamed.
	localparam logic [STATUS_W-1:0] ST_NONE   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_UNUSED = 2'd3;

	localparam int SETTLE_CYCLES    = 40;
	localparam int SINK_HOLD_CYCLES = 400;
	localparam int PHASE_ITEMS      = 450;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [DATA_IN_W-1:0]  s_tdata;   // [15:0] sample
	logic [STATUS_W-1:0]   s_tuser;   // [1:0] read_status
	logic                  m_tvalid;
	logic                  m_tready;
	logic [DATA_OUT_W-1:0] m_tdata;   // [13:0] brightness, [29:14] level
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]      cfg_data;

	int                    fail_count;
	int                    pending;
	int                    level_changes;
	int                    src_idle_pct;
	int                    sink_stall_pct;
	bit                    sink_hold_req;
	int                    samples_sent;
	int                    cfg_writes;
	logic [CONFIRM_W-1:0]  confirm_now;

	light_to_brightness_deadband uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	light_to_brightness_deadband_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending       (pending),
		.level_changes (level_changes)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit, far above the slowest correct run.
	initial begin
		#20_000_000;
		$display("light_to_brightness_deadband_tb failed");
		$finish;
	end

	// Result receiver: random stalls, plus a long hold-off on request.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (sink_hold_req) begin
				m_tready <= 1'b0;
				repeat (SINK_HOLD_CYCLES) @(negedge clk);
				sink_hold_req = 1'b0;
			end
			m_tready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// Offer one sample and wait until it is taken.
	task automatic send_sample(input logic [LEVEL_W-1:0] smp, input logic [STATUS_W-1:0] st);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= smp;
		s_tuser  <= st;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		samples_sent++;
	endtask

	// Stop offering, wait for every predicted result, then let the block settle.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Register write; callers make sure the block is idle first.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_writes++;
		if (idx == REG_CONFIRM)
			confirm_now = data[CONFIRM_W-1:0];
	endtask

	// Random deadband and confirm count, with random bits above the confirm field.
	task automatic random_setting();
		logic [DEADBAND_W-1:0] band;
		logic [CONFIRM_W-1:0]  need;
		int                    pick;
		wait_idle();
		pick = $urandom_range(99);
		if (pick < 60)
			band = 16'($urandom_range(0, 300));
		else if (pick < 85)
			band = 16'($urandom_range(0, 4000));
		else if (pick < 92)
			band = 16'($urandom);
		else if (pick < 96)
			band = '0;
		else
			band = 16'hFFFF;
		pick = $urandom_range(99);
		if (pick < 70)
			need = 4'($urandom_range(0, 4));
		else if (pick < 90)
			need = 4'($urandom_range(5, 15));
		else
			need = 4'd15;
		write_reg(REG_DEADBAND, band);
		write_reg(REG_CONFIRM, {12'($urandom), need});
	endtask

	// A new level: mostly the curve range, sometimes a knee or the full range.
	function automatic logic [LEVEL_W-1:0] pick_level();
		int pick;
		pick = $urandom_range(99);
		if (pick < 70)
			return 16'($urandom_range(0, 4000));
		else if (pick < 80)
			return 16'(CURVE_X[$urandom_range(TABLE_LEN-1)]);
		return 16'($urandom);
	endfunction

	// A steady run around one level, long enough to be confirmed. Later items
	// sometimes report no reading, so the held sample is reused.
	task automatic send_run(input logic [LEVEL_W-1:0] target);
		int                   n;
		int                   k;
		logic [STATUS_W-1:0]  st;
		n = int'(confirm_now) + 1 + $urandom_range(0, 2);
		for (k = 0; k < n; k++) begin
			case ($urandom_range(9))
				0:       st = ST_NONE;
				1:       st = ST_UNUSED;
				default: st = ST_GOOD;
			endcase
			if (k == 0)
				st = ST_GOOD;
			send_sample(target ^ 16'($urandom_range(0, 3)), st);
		end
	endtask

	// Stimulus and verdict.
	initial begin
		int ph;
		int pick;
		int phase_items;
		int k;
		logic [STATUS_W-1:0] st;
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tuser        = '0;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		sink_hold_req  = 1'b0;
		samples_sent   = 0;
		cfg_writes     = 0;
		confirm_now    = CONFIRM_RESET;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: band edges, then a drop confirmed through every status.
		send_sample(16'hFFFF, ST_GOOD);
		send_sample(16'd65485, ST_GOOD);    // exactly on the lower limit
		send_sample(16'h0000, ST_GOOD);
		send_sample(16'hABCD, ST_PARSE);    // parse error reads as zero
		send_sample(16'h5A5A, ST_NONE);     // reuse of the held sample
		send_sample(16'hFFFF, ST_UNUSED);   // unused code also reuses; zero level taken

		// Zero confirm count and zero deadband: each change is taken at once.
		wait_idle();
		write_reg(REG_CONFIRM, 16'd0);
		write_reg(REG_DEADBAND, 16'd0);
		send_sample(16'd3355, ST_GOOD);     // last knee
		send_sample(16'd3356, ST_GOOD);     // above the curve
		send_sample(16'd80, ST_GOOD);
		send_sample(16'd81, ST_GOOD);
		send_sample(16'd1, ST_GOOD);
		send_sample(16'd81, ST_GOOD);
		send_sample(16'd81, ST_GOOD);       // same level, inside a zero band
		send_sample(16'hFFFF, ST_GOOD);

		// Widest band and largest confirm count.
		wait_idle();
		write_reg(REG_DEADBAND, 16'hFFFF);
		write_reg(REG_CONFIRM, 16'hFFFF);
		send_sample(16'h0000, ST_GOOD);

		// Counter built up, then the confirm count lowered below it.
		wait_idle();
		write_reg(REG_DEADBAND, 16'd10);
		for (k = 0; k < 5; k++)
			send_sample(16'd1000, ST_GOOD);
		wait_idle();
		write_reg(REG_CONFIRM, 16'hFFF2);
		send_sample(16'd1000, ST_GOOD);

		// Random part under four idle/stall mixes.
		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 48; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 48; end
				default: begin src_idle_pct = 18; sink_stall_pct = 18; end
			endcase
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				if (phase_items % 150 == 0)
					random_setting();
				pick = $urandom_range(99);
				if (pick < 75) begin
					k = samples_sent;
					send_run(pick_level());
					phase_items += samples_sent - k;
				end else if (pick < 98) begin
					st = STATUS_W'($urandom_range(3));
					send_sample(16'($urandom), st);
					phase_items++;
				end else begin
					// Sender pause until every result is back.
					wait_idle();
				end
			end

			// Receiver holds off while steady runs keep arriving.
			if (ph == 0) begin
				wait_idle();
				write_reg(REG_DEADBAND, 16'd20);
				write_reg(REG_CONFIRM, 16'd1);
				sink_hold_req = 1'b1;
				while (sink_hold_req)
					send_run(pick_level());
			end
		end

		wait_idle();
		$display("Summary: %0d samples in four idle/stall mixes, %0d level changes checked.",
			samples_sent, level_changes);
		$display("Summary: %0d register writes, deadband and confirm count at both ends.",
			cfg_writes);
		if (fail_count == 0 && pending == 0)
			$display("light_to_brightness_deadband_tb passed");
		else
			$display("light_to_brightness_deadband_tb failed");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/ltbd_pkg.sv
rtl/ltbd_div.sv
rtl/ltbd_seg.sv
rtl/light_to_brightness_deadband.sv
rtl/ltbd_chk.sv
tb/sv/light_to_brightness_deadband_checker.sv
tb/sv/light_to_brightness_deadband_tb.sv
